/* sv/olt_pkg.sv */
// Shared types, constants and helpers for the ordered list table.
package olt_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    ACT_INSERT_FIRST = 2'd0,
    ACT_DELETE_LAST  = 2'd1,
    ACT_DELETE_AFTER = 2'd2,
    ACT_SEARCH       = 2'd3
  } olt_action_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } olt_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } olt_state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } olt_mem_req_t;

  typedef struct packed {
    logic               vld;
    olt_status_e        status;
    logic [COUNT_W-1:0] count;
  } olt_res_t;

  // store slot of a list position; pos is below DEPTH
  function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] head,
                                              logic [CNT_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + (IDX_W + 1)'(pos);
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* sv/ordered_list_table_top.sv */
// Ordered list table top level: handshakes, result register, store and sequencer.
// An ordered list of up to DEPTH (16) signed 32-bit values held in a circular
// store with one read and one write port. One request is in flight at a time;
// in_ready_o is low while a request runs or its result beat cannot be placed.
// Insert-first and delete-last finish in the accept cycle and the result beat
// shows on the next cycle. Search walks the list one entry per cycle through
// the store's read port and stops early on a hit. Delete-after walks to the
// first match at position p, drops the entry at p + 1 and moves every later
// entry down one slot, one per cycle through the same port. No clearing pass
// is needed after reset.
module ordered_list_table_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         action_i,
  input  logic signed [olt_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic [olt_pkg::COUNT_W-1:0]        entry_count_o
);

  logic                          idle;
  logic                          start;
  olt_pkg::olt_mem_req_t         mem_req;
  logic [olt_pkg::DATA_W-1:0]    rdata;
  olt_pkg::olt_res_t             res;

  logic                          out_vld_q, out_vld_d;
  olt_pkg::olt_status_e          status_q;
  logic [olt_pkg::COUNT_W-1:0]   count_q;

  assign in_ready_o = idle && (!out_vld_q || out_ready_i);
  assign start      = in_valid_i && in_ready_o;

  olt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (olt_pkg::olt_action_e'(action_i)),
    .value_i  (value_i),
    .rdata_i  (rdata),
    .idle_o   (idle),
    .mem_o    (mem_req),
    .res_o    (res)
  );

  olt_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (res.vld) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.vld) begin
      status_q <= res.status;
      count_q  <= res.count;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

endmodule

/* sv/olt_store.sv */
// Entry store: one write port, one read port with registered read data.
module olt_store (
  input  logic                              clk_i,
  input  olt_pkg::olt_mem_req_t             req_i,
  output logic [olt_pkg::DATA_W-1:0]        rdata_o
);

  logic [olt_pkg::DATA_W-1:0] mem_q [olt_pkg::DEPTH];
  logic [olt_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/olt_ctrl.sv */
// Sequencer: list pointers, scan compare and shift-down of later entries.
module olt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  olt_pkg::olt_action_e          action_i,
  input  logic [olt_pkg::DATA_W-1:0]    value_i,
  input  logic [olt_pkg::DATA_W-1:0]    rdata_i,
  output logic                          idle_o,
  output olt_pkg::olt_mem_req_t         mem_o,
  output olt_pkg::olt_res_t             res_o
);

  olt_pkg::olt_state_e         state_q, state_d;
  logic [olt_pkg::IDX_W-1:0]   head_q, head_d;
  logic [olt_pkg::CNT_W-1:0]   occ_q, occ_d;
  olt_pkg::olt_action_e        act_q, act_d;
  logic [olt_pkg::DATA_W-1:0]  val_q, val_d;
  logic [olt_pkg::CNT_W-1:0]   rd_pos_q, rd_pos_d;
  logic                        cmp_vld_q, cmp_vld_d;
  logic [olt_pkg::CNT_W-1:0]   cmp_pos_q, cmp_pos_d;

  logic [olt_pkg::CNT_W-1:0]   lim;
  logic [olt_pkg::IDX_W-1:0]   head_dec;
  logic                        issue, hit, scan_go, walk_end;

  assign head_dec = (head_q == '0) ? olt_pkg::IDX_W'(olt_pkg::DEPTH - 1)
                                   : head_q - 1'b1;

  always_comb begin
    case (state_q)
      olt_pkg::ST_SCAN: lim = (act_q == olt_pkg::ACT_SEARCH) ? occ_q : occ_q - 1'b1;
      default:          lim = occ_q;
    endcase
  end

  assign issue    = (state_q != olt_pkg::ST_IDLE) && (rd_pos_q < lim);
  assign hit      = cmp_vld_q && (rdata_i == val_q);
  assign walk_end = !cmp_vld_q && !issue;
  assign scan_go  = start_i &&
                    (((action_i == olt_pkg::ACT_SEARCH) && (occ_q != '0)) ||
                     ((action_i == olt_pkg::ACT_DELETE_AFTER) &&
                      (occ_q >= olt_pkg::CNT_W'(2))));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      olt_pkg::ST_IDLE: begin
        if (scan_go) begin
          state_d = olt_pkg::ST_SCAN;
        end
      end
      olt_pkg::ST_SCAN: begin
        if (hit) begin
          state_d = (act_q == olt_pkg::ACT_SEARCH) ? olt_pkg::ST_IDLE
                                                   : olt_pkg::ST_SHIFT;
        end else if (walk_end) begin
          state_d = olt_pkg::ST_IDLE;
        end
      end
      olt_pkg::ST_SHIFT: begin
        if (walk_end) begin
          state_d = olt_pkg::ST_IDLE;
        end
      end
      default: state_d = olt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d     = head_q;
    occ_d      = occ_q;
    act_d      = act_q;
    val_d      = val_q;
    rd_pos_d   = rd_pos_q;
    cmp_vld_d  = 1'b0;
    cmp_pos_d  = cmp_pos_q;
    mem_o      = '0;
    res_o      = '0;
    res_o.status = olt_pkg::STAT_OK;
    res_o.count  = olt_pkg::COUNT_W'(occ_q);
    case (state_q)
      olt_pkg::ST_IDLE: begin
        if (start_i) begin
          act_d    = action_i;
          val_d    = value_i;
          rd_pos_d = '0;
          case (action_i)
            olt_pkg::ACT_INSERT_FIRST: begin
              res_o.vld = 1'b1;
              if (occ_q == olt_pkg::CNT_W'(olt_pkg::DEPTH)) begin
                res_o.status = olt_pkg::STAT_FULL;
              end else begin
                head_d      = head_dec;
                occ_d       = occ_q + 1'b1;
                mem_o.we    = 1'b1;
                mem_o.waddr = head_dec;
                mem_o.wdata = value_i;
                res_o.count = olt_pkg::COUNT_W'(occ_q + 1'b1);
              end
            end
            olt_pkg::ACT_DELETE_LAST: begin
              res_o.vld = 1'b1;
              if (occ_q == '0) begin
                res_o.status = olt_pkg::STAT_MISS;
              end else begin
                occ_d       = occ_q - 1'b1;
                res_o.count = olt_pkg::COUNT_W'(occ_q - 1'b1);
              end
            end
            default: begin
              if (!scan_go) begin
                res_o.vld    = 1'b1;
                res_o.status = olt_pkg::STAT_MISS;
              end
            end
          endcase
        end
      end
      olt_pkg::ST_SCAN: begin
        mem_o.re    = issue;
        mem_o.raddr = olt_pkg::slot_of(head_q, rd_pos_q);
        cmp_vld_d   = issue;
        cmp_pos_d   = rd_pos_q;
        if (issue) begin
          rd_pos_d = rd_pos_q + 1'b1;
        end
        if (hit) begin
          if (act_q == olt_pkg::ACT_SEARCH) begin
            res_o.vld = 1'b1;
          end else begin
            // drop position p+1: pull p+2 .. tail down by one
            rd_pos_d  = cmp_pos_q + olt_pkg::CNT_W'(2);
            cmp_vld_d = 1'b0;
          end
        end else if (walk_end) begin
          res_o.vld    = 1'b1;
          res_o.status = olt_pkg::STAT_MISS;
        end
      end
      olt_pkg::ST_SHIFT: begin
        mem_o.re    = issue;
        mem_o.raddr = olt_pkg::slot_of(head_q, rd_pos_q);
        cmp_vld_d   = issue;
        cmp_pos_d   = rd_pos_q;
        if (issue) begin
          rd_pos_d = rd_pos_q + 1'b1;
        end
        if (cmp_vld_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = olt_pkg::slot_of(head_q, cmp_pos_q - 1'b1);
          mem_o.wdata = rdata_i;
        end
        if (walk_end) begin
          occ_d       = occ_q - 1'b1;
          res_o.vld   = 1'b1;
          res_o.count = olt_pkg::COUNT_W'(occ_q - 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  assign idle_o = (state_q == olt_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= olt_pkg::ST_IDLE;
      head_q    <= '0;
      occ_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      occ_q     <= occ_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    val_q     <= val_d;
    rd_pos_q  <= rd_pos_d;
    cmp_pos_q <= cmp_pos_d;
  end

endmodule

/* sim/tb_ordered_list_table_top.sv */
`timescale 1ns / 100ps
// Testbench for ordered_list_table_top: directed corner cases and random list traffic checked against a list model.
module tb_ordered_list_table_top;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int CHUNK_ITEMS  = 275;

  typedef struct {
    olt_pkg::olt_status_e        status;
    logic [olt_pkg::COUNT_W-1:0] count;
  } list_result_t;

  class list_tracker;
    logic [olt_pkg::DATA_W-1:0] slots[olt_pkg::DEPTH];
    int                         head;
    int                         fill;
    int                         errors;
    list_result_t               pending_results[$];

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function int slot(int pos);
      return (head + pos) % olt_pkg::DEPTH;
    endfunction

    function olt_pkg::olt_status_e apply(olt_pkg::olt_action_e act,
                                         logic [olt_pkg::DATA_W-1:0] val);
      case (act)
        olt_pkg::ACT_INSERT_FIRST: begin
          if (fill >= olt_pkg::DEPTH) return olt_pkg::STAT_FULL;
          head = (head + olt_pkg::DEPTH - 1) % olt_pkg::DEPTH;
          slots[head] = val;
          fill++;
          return olt_pkg::STAT_OK;
        end
        olt_pkg::ACT_DELETE_LAST: begin
          if (fill == 0) return olt_pkg::STAT_MISS;
          fill--;
          return olt_pkg::STAT_OK;
        end
        olt_pkg::ACT_DELETE_AFTER: begin
          for (int p = 0; p + 1 < fill; p++) begin
            if (slots[slot(p)] == val) begin
              for (int q = p + 1; q + 1 < fill; q++) slots[slot(q)] = slots[slot(q + 1)];
              fill--;
              return olt_pkg::STAT_OK;
            end
          end
          return olt_pkg::STAT_MISS;
        end
        default: begin
          for (int p = 0; p < fill; p++) begin
            if (slots[slot(p)] == val) return olt_pkg::STAT_OK;
          end
          return olt_pkg::STAT_MISS;
        end
      endcase
    endfunction

    function void note_request(olt_pkg::olt_action_e act, logic [olt_pkg::DATA_W-1:0] val);
      list_result_t res;
      res.status = apply(act, val);
      res.count  = olt_pkg::COUNT_W'(fill);
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [olt_pkg::COUNT_W-1:0] count);
      list_result_t res;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d count %0d", status, count);
        errors++;
        return;
      end
      res = pending_results.pop_front();
      if (status !== res.status) begin
        $error("status: expected %0d, got %0d", res.status, status);
        errors++;
      end
      if (count !== res.count) begin
        $error("entry_count: expected %0d, got %0d", res.count, count);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [1:0]                        action_i;
  logic signed [olt_pkg::DATA_W-1:0] value_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [1:0]                        status_o;
  logic [olt_pkg::COUNT_W-1:0]       entry_count_o;

  list_tracker board;
  int          sender_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          cycle_cnt;

  ordered_list_table_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(status_o, entry_count_o);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_req(olt_pkg::olt_action_e act, logic [olt_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(act, val);
    @(negedge clk_i);
  endtask

  function automatic logic [olt_pkg::DATA_W-1:0] pick_value();
    logic [olt_pkg::DATA_W-1:0] pool[8];
    pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'd99999, -32'sd99999,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_A5A5};
    if ($urandom_range(99) < 75) return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic olt_pkg::olt_action_e pick_action(int ins_pct);
    int r;
    r = $urandom_range(99);
    if (r < ins_pct) return olt_pkg::ACT_INSERT_FIRST;
    if (r < ins_pct + 15) return olt_pkg::ACT_DELETE_LAST;
    if (r < ins_pct + 50) return olt_pkg::ACT_DELETE_AFTER;
    return olt_pkg::ACT_SEARCH;
  endfunction

  task automatic run_random(int items);
    int ins_pct;
    ins_pct = 50;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) ins_pct = ($urandom_range(1) != 0) ? 55 : 15;
      send_req(pick_action(ins_pct), pick_value());
    end
  endtask

  initial begin
    board           = new();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b0;
    cycle_cnt       = 0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    action_i        = olt_pkg::ACT_INSERT_FIRST;
    value_i         = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty and short list corner cases
    send_req(olt_pkg::ACT_SEARCH, 32'h0);
    send_req(olt_pkg::ACT_DELETE_LAST, 32'h0);
    send_req(olt_pkg::ACT_DELETE_AFTER, 32'h0);
    send_req(olt_pkg::ACT_INSERT_FIRST, 32'h8000_0000);
    send_req(olt_pkg::ACT_DELETE_AFTER, 32'h8000_0000);
    send_req(olt_pkg::ACT_INSERT_FIRST, 32'h7FFF_FFFF);
    send_req(olt_pkg::ACT_INSERT_FIRST, 32'h0);
    send_req(olt_pkg::ACT_INSERT_FIRST, 32'hFFFF_FFFF);
    send_req(olt_pkg::ACT_SEARCH, 32'h8000_0000);
    // match on the tail only does not count
    send_req(olt_pkg::ACT_DELETE_AFTER, 32'h8000_0000);
    send_req(olt_pkg::ACT_SEARCH, 32'd99999);
    send_req(olt_pkg::ACT_INSERT_FIRST, 32'd99999);
    send_req(olt_pkg::ACT_INSERT_FIRST, -32'sd99999);
    send_req(olt_pkg::ACT_DELETE_AFTER, -32'sd99999);
    send_req(olt_pkg::ACT_SEARCH, 32'd99999);
    send_req(olt_pkg::ACT_DELETE_AFTER, 32'h0);
    // fill up, then one insert past full
    while (board.fill < olt_pkg::DEPTH) send_req(olt_pkg::ACT_INSERT_FIRST, $urandom);
    send_req(olt_pkg::ACT_INSERT_FIRST, 32'h1234_5678);
    send_req(olt_pkg::ACT_DELETE_AFTER, 32'hFFFF_FFFF);
    send_req(olt_pkg::ACT_DELETE_LAST, 32'hFFFF_FFFF);

    run_random(CHUNK_ITEMS);
    sender_idle_pct = 70;
    recv_stall_pct  = 0;
    run_random(CHUNK_ITEMS);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req        = 1'b1;
    run_random(40);
    recv_stall_pct  = 70;
    run_random(CHUNK_ITEMS);
    sender_idle_pct = 21;
    recv_stall_pct  = 21;
    run_random(CHUNK_ITEMS - 40);
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
